/* sv/mean_filter_7x7_core_defines.svh */
// assertion helpers shared by the filter rtl
`ifndef MEAN_FILTER_7X7_CORE_DEFINES_SVH
`define MEAN_FILTER_7X7_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MF7_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MF7_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mf7_pkg.sv */
`timescale 1ns / 1ps
package mf7_pkg;

  // frame limits and window geometry
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned Radius    = 3;
  localparam int unsigned Win       = 2 * Radius + 1;
  localparam int unsigned Lines     = 2 * Radius;

  // field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned ColW   = 10;
  localparam int unsigned RowW   = 12;
  localparam int unsigned CfgWW  = 11;
  localparam int unsigned CfgHW  = 13;
  localparam int unsigned LineWordW = Lines * PixW;
  localparam int unsigned ColSumW = 11;
  localparam int unsigned SumW    = 14;

  // rounded divide by 49: (sum + 24) * 21400 >> 20 is exact for sums below 43683
  localparam logic [SumW-1:0] RoundBias  = 14'd24;
  localparam logic [14:0]     RecipMul   = 15'd21400;
  localparam int unsigned     RecipShift = 20;
  localparam logic [SumW-1:0] MaxSum     = 14'd12495;

  // register map, selected by paddr[2]
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam logic [CfgWW-1:0] WidthReset  = 11'd512;
  localparam logic [CfgHW-1:0] HeightReset = 13'd512;

endpackage

/* sv/mean_filter_7x7_core.sv */
`timescale 1ns / 1ps
`include "mean_filter_7x7_core_defines.svh"
// pipeline: an accepted pixel goes through the stage 1, 2, 3 and output registers
// throughput: one pixel per unstalled clock, set by the single read-modify-write
//   of the line memory word for each column (forwarded when the same column repeats)
// reset: counters, column sums and valid flags clear; width and height return to 512;
//   the line memory keeps no reset and needs no clearing pass
module mean_filter_7x7_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel stream in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  input  logic        frame_start_i,
  // result stream out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  mean_value_o,
  output logic        valid_res_o,
  output logic [11:0] center_row_o,
  output logic [9:0]  center_col_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mf7_pkg::*;

  // configuration registers
  logic [CfgWW-1:0] width_q;
  logic [CfgHW-1:0] height_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegWidth:  width_q  <= pwdata[CfgWW-1:0];
        RegHeight: height_q <= pwdata[CfgHW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegWidth:  prdata = {{(32-CfgWW){1'b0}}, width_q};
      RegHeight: prdata = {{(32-CfgHW){1'b0}}, height_q};
      default:   prdata = '0;
    endcase
  end

  // effective frame size
  logic [CfgWW-1:0] w_eff;
  logic [CfgHW-1:0] h_eff;

  always_comb begin
    if (width_q == '0)                        w_eff = CfgWW'(1);
    else if (width_q > CfgWW'(MaxWidth))      w_eff = CfgWW'(MaxWidth);
    else                                      w_eff = width_q;
    if (height_q == '0)                       h_eff = CfgHW'(1);
    else if (height_q > CfgHW'(MaxHeight))    h_eff = CfgHW'(MaxHeight);
    else                                      h_eff = height_q;
  end

  // pipeline occupancy and flow control
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;
  logic in_acc;

  assign out_free   = !out_v_q || !out_stall_i;
  assign s3_adv     = s3_v_q && out_free;
  assign s3_free    = !s3_v_q || out_free;
  assign s2_adv     = s2_v_q && s3_free;
  assign s2_free    = !s2_v_q || s3_free;
  assign s1_adv     = s1_v_q && s2_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;

  // raster position of the incoming pixel and next counter values
  logic [ColW-1:0] col_q, col_d, c_sel;
  logic [RowW-1:0] row_q, row_d, r_sel, r_base;
  logic [ColW-1:0] c_base;
  logic [CfgHW-1:0] r_inc, r_nxt;
  logic [CfgWW-1:0] c_nxt;

  always_comb begin
    c_base = frame_start_i ? '0 : col_q;
    r_base = frame_start_i ? '0 : row_q;
    if ({1'b0, c_base} >= w_eff) begin
      c_sel = '0;
      r_inc = {1'b0, r_base} + CfgHW'(1);
    end else begin
      c_sel = c_base;
      r_inc = {1'b0, r_base};
    end
    r_sel = (r_inc >= h_eff) ? '0 : r_inc[RowW-1:0];
    c_nxt = {1'b0, c_sel} + CfgWW'(1);
    r_nxt = {1'b0, r_sel} + CfgHW'(1);
    if (c_nxt >= w_eff) begin
      col_d = '0;
      row_d = (r_nxt >= h_eff) ? '0 : r_nxt[RowW-1:0];
    end else begin
      col_d = c_nxt[ColW-1:0];
      row_d = r_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 registers: pixel, column and output tags
  logic [PixW-1:0] px1_q;
  logic [ColW-1:0] c1_q;
  logic [RowW-1:0] crow1_q;
  logic [ColW-1:0] ccol1_q;
  logic            win1_q;
  logic            win0;

  assign win0 = (r_sel >= RowW'(Lines)) && (c_sel >= ColW'(Lines));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q   <= pixel_i;
      c1_q    <= c_sel;
      win1_q  <= win0;
      crow1_q <= r_sel - RowW'(Radius);
      ccol1_q <= c_sel - ColW'(Radius);
    end
  end

  // line memory: one word per column holding the six stored lines
  logic [LineWordW-1:0] line_mem [MaxWidth];
  logic [LineWordW-1:0] rd_data_q, fwd_data_q, line_word, wr_word;
  logic                 fwd_q, fwd_hit;

  assign line_word = fwd_q ? fwd_data_q : rd_data_q;
  assign wr_word   = {px1_q, line_word[LineWordW-1:PixW]};
  assign fwd_hit   = s1_adv && (c_sel == c1_q);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[c1_q] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= line_mem[c_sel];
    end
  end

  // same column written as it is read: hand the new word over directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= fwd_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= wr_word;
    end
  end

  // sum of the incoming window column
  logic [ColSumW-1:0] col_sum;

  always_comb begin
    col_sum = ColSumW'(px1_q);
    for (int i = 0; i < Lines; i++) begin
      col_sum = col_sum + ColSumW'(line_word[i*PixW +: PixW]);
    end
  end

  // stage 2 registers
  logic [ColSumW-1:0] colsum2_q;
  logic [RowW-1:0]    crow2_q;
  logic [ColW-1:0]    ccol2_q;
  logic               win2_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      colsum2_q <= col_sum;
      crow2_q   <= crow1_q;
      ccol2_q   <= ccol1_q;
      win2_q    <= win1_q;
    end
  end

  // window sum: the newest column sum plus the six held before it
  logic [ColSumW-1:0] cs_q [Win];
  logic [SumW-1:0]    sum_d;

  always_comb begin
    sum_d = SumW'(colsum2_q);
    for (int i = 1; i < Win; i++) begin
      sum_d = sum_d + SumW'(cs_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Win; i++) begin
        cs_q[i] <= '0;
      end
    end else if (s2_adv) begin
      for (int i = 0; i < Win - 1; i++) begin
        cs_q[i] <= cs_q[i+1];
      end
      cs_q[Win-1] <= colsum2_q;
    end
  end

  // stage 3 registers
  logic [SumW-1:0] sum3_q;
  logic [RowW-1:0] crow3_q;
  logic [ColW-1:0] ccol3_q;
  logic            win3_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      sum3_q  <= sum_d;
      crow3_q <= crow2_q;
      ccol3_q <= ccol2_q;
      win3_q  <= win2_q;
    end
  end

  // rounded mean by reciprocal multiply
  logic [SumW-1:0]   biased;
  logic [SumW+14:0]  prod;
  logic [PixW-1:0]   mean3;

  assign biased = sum3_q + RoundBias;
  assign prod   = (SumW+15)'(biased) * (SumW+15)'(RecipMul);
  assign mean3  = prod[RecipShift +: PixW];

  // output register
  logic [PixW-1:0] mean_q;
  logic [RowW-1:0] crow_q;
  logic [ColW-1:0] ccol_q;
  logic            res_q;

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      mean_q <= win3_q ? mean3 : '0;
      crow_q <= win3_q ? crow3_q : '0;
      ccol_q <= win3_q ? ccol3_q : '0;
      res_q  <= win3_q;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q  <= in_valid_i;
      if (s2_free) s2_v_q  <= s1_v_q;
      if (s3_free) s3_v_q  <= s2_v_q;
      if (out_free) out_v_q <= s3_v_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign mean_value_o = mean_q;
  assign valid_res_o  = res_q;
  assign center_row_o = crow_q;
  assign center_col_o = ccol_q;

  // checks
  `MF7_ASSERT_NOW(a_blank_result, out_valid_o && !valid_res_o, mean_value_o == '0 && center_row_o == '0 && center_col_o == '0, "non-window result carries data")
  `MF7_ASSERT_NOW(a_sum_range, s3_v_q && win3_q, sum3_q <= MaxSum, "window sum exceeds 49 full-scale pixels")
  `MF7_ASSERT_NEXT(a_fwd_taken, in_acc && fwd_hit, fwd_q && s1_v_q, "same-column word not forwarded")

endmodule
